>>> rtl/hcb_pkg.sv
// shared constants for the huffman code builder
`timescale 1ns / 1ps
package hcb_pkg;
	localparam int DEF_MAX_SYMBOLS = 32;
	localparam int DEF_FREQ_BITS   = 16;
	localparam int SYM_W           = 8;
	localparam int FREQ_W          = 16;
	localparam int CODE_W          = 31;
	localparam int LEN_W           = 5;
endpackage

>>> rtl/huffman_code_builder.sv
// huffman code builder: symbol loading, tree build and depth-first code walk
// Symbols load one per transaction, one per cycle, while busy is low. The transaction
// with final_item set loads its symbol too and starts the build; busy then stays high
// until the last code has been presented. The build sorts the working list once with a
// single shared comparator (insertion sort, one compare per cycle), then merges n-1 times;
// each merge reads the two lowest entries (S_MA, S_MB), then inserts the new parent with
// one compare per list entry it passes. The walk visits each tree node with a fetch and an
// evaluate step, plus a pop step for each leaf popped from the stack. Each code appears for
// exactly one cycle with result_strobe high; the receiver cannot stall, so results must be
// taken when they appear. last_code marks the final leaf, and overflow reports that
// symbols beyond the capacity were dropped from this set.
`timescale 1ns / 1ps
module huffman_code_builder #(
	parameter int MAX_SYMBOLS = hcb_pkg::DEF_MAX_SYMBOLS,
	parameter int FREQ_BITS   = hcb_pkg::DEF_FREQ_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [hcb_pkg::SYM_W-1:0]  symbol,
	input  logic [hcb_pkg::FREQ_W-1:0] frequency,
	input  logic                       final_item,
	output logic                       result_strobe,
	output logic [hcb_pkg::SYM_W-1:0]  leaf_symbol,
	output logic [hcb_pkg::CODE_W-1:0] code_bits,
	output logic [hcb_pkg::LEN_W-1:0]  code_length,
	output logic                       last_code,
	output logic                       overflow
);
	// widths derived from the capacity
	localparam int FB    = (FREQ_BITS < hcb_pkg::FREQ_W) ? FREQ_BITS : hcb_pkg::FREQ_W;
	localparam int LB    = $clog2(MAX_SYMBOLS);
	localparam int CB    = $clog2(MAX_SYMBOLS + 1);
	localparam int NODES = 2 * MAX_SYMBOLS - 1;
	localparam int NB    = $clog2(NODES);
	localparam int WB    = FB + LB;
	localparam int SW    = hcb_pkg::SYM_W;
	localparam int CW    = hcb_pkg::CODE_W;
	localparam int LW    = hcb_pkg::LEN_W;

	// sequencer codes
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SLOAD  = 4'd1;
	localparam logic [3:0] S_SCMP   = 4'd2;
	localparam logic [3:0] S_MA     = 4'd3;
	localparam logic [3:0] S_MB     = 4'd4;
	localparam logic [3:0] S_WSTART = 4'd5;
	localparam logic [3:0] S_WFETCH = 4'd6;
	localparam logic [3:0] S_WEVAL  = 4'd7;
	localparam logic [3:0] S_WPOP   = 4'd8;

	typedef struct packed {
		logic          leaf;
		logic [SW-1:0] sym;
		logic [NB-1:0] left;
		logic [NB-1:0] right;
	} node_t;

	typedef struct packed {
		logic [NB-1:0] node;
		logic [CW-1:0] code;
		logic [LW-1:0] len;
	} walk_t;

	logic [3:0]    state_q;
	logic [CB-1:0] cnt_q;
	logic          ovf_q;
	logic [CB-1:0] n_q;
	logic [CB-1:0] i_q;
	logic [CB-1:0] j_q;
	logic          ins_q;
	logic [WB-1:0] key_w_q;
	logic [NB-1:0] key_n_q;
	logic [WB-1:0] a_w_q;
	logic [NB-1:0] a_n_q;
	logic [NB-1:0] nn_q;
	logic [CB-1:0] sp_q;
	walk_t         cur_q;
	node_t         nd_rd_q;
	walk_t         stk_rd_q;

	// working list in flops, one read address a cycle
	logic [WB-1:0] wl_w [MAX_SYMBOLS];
	logic [NB-1:0] wl_n [MAX_SYMBOLS];

	// tree node and walk stack memories
	node_t node_mem [NODES];
	walk_t stack_mem [MAX_SYMBOLS];

	logic          accept;
	logic          store;
	logic [CB-1:0] n_new;
	logic [LB-1:0] rd_idx;
	logic [WB-1:0] rd_w;
	logic [NB-1:0] rd_n;
	logic [WB:0]   diff;
	logic          move;
	logic          list_wr;
	logic [LB-1:0] list_wr_idx;
	logic [WB-1:0] list_wr_w;
	logic [NB-1:0] list_wr_n;
	logic          list_shift;
	logic          node_wr;
	logic [NB-1:0] node_wr_idx;
	node_t         node_wr_data;
	logic          push;
	logic          pop;
	walk_t         push_data;
	logic [CB-1:0] j_m1;
	logic [CB-1:0] sp_m1;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign store  = (cnt_q < CB'(MAX_SYMBOLS));
	assign n_new  = store ? cnt_q + CB'(1) : cnt_q;
	assign j_m1   = j_q - CB'(1);
	assign sp_m1  = sp_q - CB'(1);

	// single read port of the working list
	always_comb begin
		unique case (state_q)
			S_SLOAD: rd_idx = i_q[LB-1:0];
			S_SCMP:  rd_idx = j_m1[LB-1:0];
			S_MB:    rd_idx = LB'(1);
			default: rd_idx = '0;
		endcase
	end
	assign rd_w = wl_w[rd_idx];
	assign rd_n = wl_n[rd_idx];

	// shared comparator: entry above key, or not below it when inserting a parent
	assign diff = {1'b0, rd_w} - {1'b0, key_w_q} - (WB+1)'(ins_q ? 1'b0 : 1'b1);
	assign move = (j_q != '0) && !diff[WB];

	always_comb begin
		list_wr      = 1'b0;
		list_wr_idx  = cnt_q[LB-1:0];
		list_wr_w    = WB'(frequency[FB-1:0]);
		list_wr_n    = NB'(cnt_q);
		list_shift   = 1'b0;
		node_wr      = 1'b0;
		node_wr_idx  = NB'(cnt_q);
		node_wr_data = '{leaf: 1'b1, sym: symbol, left: '0, right: '0};
		push         = 1'b0;
		pop          = 1'b0;
		push_data    = '{node: nd_rd_q.right, code: {cur_q.code[CW-2:0], 1'b1},
			len: cur_q.len + LW'(1)};
		unique case (state_q)
			S_IDLE: begin
				if (accept && store) begin
					list_wr = 1'b1;
					node_wr = 1'b1;
				end
			end
			S_SCMP: begin
				list_wr   = 1'b1;
				list_wr_w = move ? rd_w : key_w_q;
				list_wr_n = move ? rd_n : key_n_q;
				list_wr_idx = j_q[LB-1:0];
			end
			S_MB: begin
				list_shift   = 1'b1;
				node_wr      = 1'b1;
				node_wr_idx  = nn_q;
				node_wr_data = '{leaf: 1'b0, sym: '0, left: a_n_q, right: rd_n};
			end
			S_WEVAL: begin
				if (nd_rd_q.leaf) begin
					pop = (sp_q != '0);
				end else begin
					push = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// working list storage
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_SYMBOLS; k++) begin
			if (list_shift) begin
				if (k + 2 < MAX_SYMBOLS) begin
					wl_w[k] <= wl_w[(k + 2) % MAX_SYMBOLS];
					wl_n[k] <= wl_n[(k + 2) % MAX_SYMBOLS];
				end
			end else if (list_wr && list_wr_idx == LB'(k)) begin
				wl_w[k] <= list_wr_w;
				wl_n[k] <= list_wr_n;
			end
		end
	end

	// tree nodes, registered read
	always_ff @(posedge clk) begin
		if (node_wr) begin
			node_mem[node_wr_idx] <= node_wr_data;
		end
		nd_rd_q <= node_mem[cur_q.node];
	end

	// walk stack, registered read
	always_ff @(posedge clk) begin
		if (push) begin
			stack_mem[sp_q[LB-1:0]] <= push_data;
		end
		if (pop) begin
			stk_rd_q <= stack_mem[sp_m1[LB-1:0]];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			ovf_q         <= 1'b0;
			n_q           <= '0;
			i_q           <= '0;
			j_q           <= '0;
			ins_q         <= 1'b0;
			nn_q          <= '0;
			sp_q          <= '0;
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (store) begin
							cnt_q <= n_new;
						end else begin
							ovf_q <= 1'b1;
						end
						if (final_item) begin
							n_q   <= n_new;
							nn_q  <= NB'(n_new);
							i_q   <= CB'(1);
							ins_q <= 1'b0;
							state_q <= (n_new > CB'(1)) ? S_SLOAD : S_WSTART;
						end
					end
				end
				S_SLOAD: begin
					key_w_q <= rd_w;
					key_n_q <= rd_n;
					j_q     <= i_q;
					state_q <= S_SCMP;
				end
				S_SCMP: begin
					if (move) begin
						j_q <= j_m1;
					end else if (ins_q) begin
						state_q <= (n_q > CB'(1)) ? S_MA : S_WSTART;
					end else if (i_q + CB'(1) == n_q) begin
						state_q <= S_MA;
					end else begin
						i_q     <= i_q + CB'(1);
						state_q <= S_SLOAD;
					end
				end
				S_MA: begin
					a_w_q   <= rd_w;
					a_n_q   <= rd_n;
					state_q <= S_MB;
				end
				S_MB: begin
					key_w_q <= a_w_q + rd_w;
					key_n_q <= nn_q;
					nn_q    <= nn_q + NB'(1);
					j_q     <= n_q - CB'(2);
					n_q     <= n_q - CB'(1);
					ins_q   <= 1'b1;
					state_q <= S_SCMP;
				end
				S_WSTART: begin
					cur_q   <= '{node: rd_n, code: '0, len: '0};
					sp_q    <= '0;
					state_q <= S_WFETCH;
				end
				S_WFETCH: begin
					state_q <= S_WEVAL;
				end
				S_WEVAL: begin
					if (nd_rd_q.leaf) begin
						result_strobe <= 1'b1;
						leaf_symbol   <= nd_rd_q.sym;
						code_bits     <= cur_q.code;
						code_length   <= cur_q.len;
						last_code     <= (sp_q == '0);
						overflow      <= ovf_q;
						if (sp_q == '0) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							sp_q    <= sp_m1;
							state_q <= S_WPOP;
						end
					end else begin
						sp_q    <= sp_q + CB'(1);
						cur_q   <= '{node: nd_rd_q.left, code: {cur_q.code[CW-2:0], 1'b0},
							len: cur_q.len + LW'(1)};
						state_q <= S_WFETCH;
					end
				end
				S_WPOP: begin
					cur_q   <= stk_rd_q;
					state_q <= S_WFETCH;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
